// ----- sv/sle_pkg.sv -----
// Package for the sprite line evaluator: payload structs, the store write
// request, mode and register codes, and default sizes.
// Used by sle_sprite_ram and sprite_line_evaluator; depends on nothing.
package sle_pkg;

  // Default sizes handed to the top level parameters.
  localparam int unsigned NumSpritesDef = 64;
  localparam int unsigned MaxPerLineDef = 8;

  // Store geometry: 256 bytes, four bytes (Y, tile, attribute, X) per sprite.
  localparam int unsigned StoreWords = 64;
  localparam int unsigned SprIdxW    = 6;

  // Y values at or above this hide the sprite.
  localparam logic [7:0] HideY = 8'hEF;

  // Item modes.
  localparam logic [1:0] ModeWrite = 2'd0;
  localparam logic [1:0] ModeEval  = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgRenderEnable   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSpriteTall     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSpriteTableHigh = 2'd2;

  typedef logic [SprIdxW-1:0] spr_idx_t;

  // One sprite entry as read from the store: byte 0 Y, 1 tile, 2 attr, 3 X.
  typedef logic [3:0][7:0] sprite_t;

  // Single byte write into the store.
  typedef struct packed {
    logic       en;
    spr_idx_t   word;
    logic [1:0] lane;
    logic [7:0] data;
  } ram_wr_t;

  // Input word.
  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] store_index;
    logic [7:0] store_byte;
    logic [7:0] scanline;
  } in_t;

  // Output word.
  typedef struct packed {
    logic        hit;
    logic [5:0]  sprite_number;
    logic [12:0] pattern_addr;
    logic [1:0]  palette_select;
    logic        behind_background;
    logic        mirror_horizontal;
    logic [7:0]  x_position;
    logic        line_overflow;
    logic        overflow_status;
    logic        last;
  } out_t;

  // One buffered hit waiting for the end of the scan.
  typedef struct packed {
    logic [5:0]  sprite_number;
    logic [12:0] pattern_addr;
    logic [1:0]  palette_select;
    logic        behind_background;
    logic        mirror_horizontal;
    logic [7:0]  x_position;
  } hit_t;

endpackage

// ----- sv/sle_sprite_ram.sv -----
// Sprite attribute store: 64 words of four bytes, byte-lane writes and a
// whole-word registered synchronous read.
// Depends on sle_pkg.
module sle_sprite_ram (
  input  logic               clk_i,
  input  sle_pkg::ram_wr_t   wr_i,
  input  sle_pkg::spr_idx_t  rd_addr_i,
  output sle_pkg::sprite_t   rd_data_o
);

  sle_pkg::sprite_t mem_q [sle_pkg::StoreWords];
  sle_pkg::sprite_t rd_data_q;

  // Byte-lane write port.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.word][wr_i.lane] <= wr_i.data;
    end
  end

  // Registered word read.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- sv/sprite_line_evaluator.sv -----
// Top level of the sprite line evaluator: control sequencer, range check,
// pattern address generation and the per-line result buffer.
// Depends on sle_pkg and sle_sprite_ram.

// A write or clear word is taken in the idle state, which it does not leave.
// An evaluation reads one sprite entry (all four bytes at once) per cycle
// from the store, and the scan ends early when a sprite past MAX_PER_LINE
// is in range; with rendering off the scan is skipped. The hits are held in
// a small buffer until the scan ends, because the overflow bits and the last
// mark are known only then, and are then sent one word per cycle while the
// output is not stalled (one empty word when there is no hit). No new input
// word is taken until the last result word has been taken.
module sprite_line_evaluator #(
  parameter int unsigned NUM_SPRITES  = sle_pkg::NumSpritesDef,
  parameter int unsigned MAX_PER_LINE = sle_pkg::MaxPerLineDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write port.
  input  logic                         cfg_we_i,
  input  logic [sle_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic                         cfg_wdata_i,
  // Input channel.
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  sle_pkg::in_t                 in_i,
  // Output channel.
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output sle_pkg::out_t                out_o
);

  localparam int unsigned ScanW = $clog2(NUM_SPRITES + 1);
  localparam int unsigned CntW  = $clog2(MAX_PER_LINE + 1);
  localparam int unsigned IdxW  = (MAX_PER_LINE > 1) ? $clog2(MAX_PER_LINE) : 1;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StEmit = 2'd2;

  // Configuration registers.
  logic render_en_q, tall_q, table_hi_q;

  // Control state.
  logic [1:0]        state_q, state_d;
  logic [ScanW-1:0]  scan_q, scan_d;
  logic              ev_vld_q, ev_vld_d;
  sle_pkg::spr_idx_t ev_num_q, ev_num_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   rd_q, rd_d;
  logic              lovf_q, lovf_d;
  logic              flag_q, flag_d;
  logic [7:0]        line_q, line_d;

  sle_pkg::hit_t     buf_q [MAX_PER_LINE];
  logic              buf_we;

  sle_pkg::ram_wr_t  ram_wr;
  sle_pkg::spr_idx_t rd_addr;
  sle_pkg::sprite_t  spr;

  logic              in_acc, out_acc;
  logic [8:0]        diff;
  logic              in_rng;
  logic [3:0]        row;
  logic [12:0]       addr;
  sle_pkg::hit_t     ev_entry;
  logic [CntW-1:0]   total;
  logic              last;
  sle_pkg::hit_t     rd_entry;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_o && !out_stall_i;
  assign rd_addr = sle_pkg::spr_idx_t'(scan_q);

  sle_sprite_ram u_ram (
    .clk_i     (clk_i),
    .wr_i      (ram_wr),
    .rd_addr_i (rd_addr),
    .rd_data_o (spr)
  );

  // Configuration register writes; an unknown index is ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      render_en_q <= 1'b0;
      tall_q      <= 1'b0;
      table_hi_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sle_pkg::CfgRenderEnable:    render_en_q <= cfg_wdata_i;
        sle_pkg::CfgSpriteTall:      tall_q      <= cfg_wdata_i;
        sle_pkg::CfgSpriteTableHigh: table_hi_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Range check on the entry read last cycle. The row offset is line - Y - 1,
  // negative when the line lies above the sprite.
  assign diff   = {1'b0, line_q} - {1'b0, spr[0]} - 9'd1;
  assign in_rng = (spr[0] < sle_pkg::HideY) && !diff[8] && (diff[7:4] == 4'd0) &&
                  (tall_q || !diff[3]);

  // Vertical flip mirrors the row within the sprite height.
  always_comb begin
    row = diff[3:0];
    if (spr[2][7]) begin
      row = tall_q ? ~diff[3:0] : {1'b0, ~diff[2:0]};
    end
  end

  // Pattern row address: tall sprites take the bank from tile bit 0 and the
  // bottom half from the next tile.
  assign addr = tall_q ? {spr[1][0], spr[1][7:1], row[3], 1'b0, row[2:0]}
                       : {table_hi_q, spr[1], 1'b0, row[2:0]};

  assign ev_entry.sprite_number     = ev_num_q;
  assign ev_entry.pattern_addr      = addr;
  assign ev_entry.palette_select    = spr[2][1:0];
  assign ev_entry.behind_background = spr[2][5];
  assign ev_entry.mirror_horizontal = spr[2][6];
  assign ev_entry.x_position        = spr[3];

  // Sequencer: idle, scan the store, then send the buffered results.
  always_comb begin
    state_d  = state_q;
    scan_d   = scan_q;
    ev_vld_d = 1'b0;
    ev_num_d = ev_num_q;
    cnt_d    = cnt_q;
    rd_d     = rd_q;
    lovf_d   = lovf_q;
    flag_d   = flag_q;
    line_d   = line_q;
    buf_we   = 1'b0;
    ram_wr   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          rd_d = '0;
          unique case (in_i.mode)
            sle_pkg::ModeWrite: begin
              ram_wr.en   = 1'b1;
              ram_wr.word = in_i.store_index[7:2];
              ram_wr.lane = in_i.store_index[1:0];
              ram_wr.data = in_i.store_byte;
            end
            sle_pkg::ModeClear: flag_d = 1'b0;
            sle_pkg::ModeEval: begin
              cnt_d   = '0;
              lovf_d  = 1'b0;
              scan_d  = '0;
              line_d  = in_i.scanline;
              state_d = render_en_q ? StScan : StEmit;
            end
            default: ;
          endcase
        end
      end
      StScan: begin
        if (scan_q < ScanW'(NUM_SPRITES)) begin
          ev_vld_d = 1'b1;
          ev_num_d = rd_addr;
          scan_d   = scan_q + ScanW'(1);
        end
        if (ev_vld_q && in_rng) begin
          if (cnt_q == CntW'(MAX_PER_LINE)) begin
            lovf_d   = 1'b1;
            flag_d   = 1'b1;
            ev_vld_d = 1'b0;
            state_d  = StEmit;
          end else begin
            buf_we = 1'b1;
            cnt_d  = cnt_q + CntW'(1);
          end
        end
        if (scan_q == ScanW'(NUM_SPRITES) && !ev_vld_q) begin
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_acc) begin
          if (last) begin
            state_d = StIdle;
          end else begin
            rd_d = rd_q + CntW'(1);
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      scan_q   <= '0;
      ev_vld_q <= 1'b0;
      cnt_q    <= '0;
      rd_q     <= '0;
      lovf_q   <= 1'b0;
      flag_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      scan_q   <= scan_d;
      ev_vld_q <= ev_vld_d;
      cnt_q    <= cnt_d;
      rd_q     <= rd_d;
      lovf_q   <= lovf_d;
      flag_q   <= flag_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ev_num_q <= ev_num_d;
    line_q   <= line_d;
    if (buf_we) begin
      buf_q[cnt_q[IdxW-1:0]] <= ev_entry;
    end
  end

  // Result words: the buffered hits, or one empty word when there are none.
  assign total    = (cnt_q == '0) ? CntW'(1) : cnt_q;
  assign last     = ({1'b0, rd_q} + (CntW + 1)'(1)) == {1'b0, total};
  assign rd_entry = buf_q[rd_q[IdxW-1:0]];

  always_comb begin
    out_o = '0;
    if (cnt_q != '0) begin
      out_o.hit               = 1'b1;
      out_o.sprite_number     = rd_entry.sprite_number;
      out_o.pattern_addr      = rd_entry.pattern_addr;
      out_o.palette_select    = rd_entry.palette_select;
      out_o.behind_background = rd_entry.behind_background;
      out_o.mirror_horizontal = rd_entry.mirror_horizontal;
      out_o.x_position        = rd_entry.x_position;
    end
    out_o.line_overflow   = lovf_q;
    out_o.overflow_status = flag_q;
    out_o.last            = last;
  end

  assign out_valid_o = (state_q == StEmit);
  assign in_stall_o  = (state_q != StIdle);

`ifndef SYNTHESIS
  // The hit count never passes the buffer depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_PER_LINE))
    else $error("hit count past buffer depth");

  // The read pointer stays inside the words of this evaluation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (rd_q < total))
    else $error("result read pointer out of range");

  // A line overflow always shows in the sticky status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.line_overflow) |-> out_o.overflow_status)
    else $error("line overflow without sticky status");

  // An empty word is the only word of its evaluation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_o.hit) |-> (out_o.last && !out_o.line_overflow))
    else $error("empty result not final");

  // Taking the final word frees the input side.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.last) |=> !in_stall_o)
    else $error("input still stalled after final result");
`endif

endmodule
